// ===== hdl/cbg_pkg.sv =====
// Shared types and constants for the growable character buffer.
// Depends on nothing; used by the top level and its RAM instance sizing.
`timescale 1ns / 1ps

package cbg_pkg;

    // Size of the byte store and upper bound of the logical capacity.
    localparam int unsigned MAX_CAPACITY = 32767;

    // Field widths.
    localparam int unsigned OFF_W    = 15;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CFG_W    = 15;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [OFF_W-1:0] CAP_MAX   = OFF_W'(MAX_CAPACITY);
    localparam logic [OFF_W:0]   CAP_MAX_X = (OFF_W + 1)'(MAX_CAPACITY);

    // Percent scale of the multiplicative growth rule.
    localparam int unsigned PCT      = 100;
    localparam int unsigned PCT_W    = 7;
    // Product of free space and saturated factor.
    localparam int unsigned PROD_W   = 22;
    // Division by PCT as a multiplication by a rounded-up reciprocal.
    localparam int unsigned RECIP_SHIFT = 29;
    localparam int unsigned RECIP_W     = 23;
    localparam int unsigned RECIP_MULT  = ((1 << RECIP_SHIFT) + PCT - 1) / PCT;
    localparam int unsigned QPROD_W     = PROD_W + RECIP_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD         = 3'd0,
        FN_GET         = 3'd1,
        FN_RETRACT     = 3'd2,
        FN_RETRACT_MRK = 3'd3,
        FN_SET_MARK    = 3'd4,
        FN_RESET       = 3'd5,
        FN_PACK        = 3'd6
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_END     = 2'd2
    } t_status;

    typedef enum logic [MODE_W-1:0] {
        GM_FIXED = 2'd0,
        GM_ADD   = 2'd1,
        GM_MULT  = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GROWTH_MODE   = 2'd0,
        CFG_GROWTH_FACTOR = 2'd1,
        CFG_INIT_CAP      = 2'd2
    } t_cfg_idx;

endpackage

// ===== hdl/char_buffer_with_growth_policy_top.sv =====
// Top level of the growable character buffer with mark and retract.
// Depends on cbg_pkg (types, constants) and cbg_ram (byte store).
`timescale 1ns / 1ps

// This block is a lexer input buffer. Each input transfer carries one
// operation (add, get, retract, retract to mark, set mark, reset, pack) and
// produces exactly one output transfer with a status, the byte read by a get
// and a snapshot of the offsets, capacity and flags after the operation.
// The bytes live in a synchronous RAM of MAX_CAPACITY entries with
// registered read data; the read for a get is issued in the cycle the input
// transfer is taken, and the operation commits in EXEC once the output
// register is free. One operation is in flight at a time: a new input
// transfer is taken only while idle, after the previous one has committed.
// An add that finds the buffer full in multiplicative mode first passes
// through the MUL and DIV states, where the growth increment goes through
// a registered multiply and a registered multiply by the reciprocal of one
// hundred, before the operation commits.
// Results sit in an output register, so a stalled output only holds up the
// commit of the next operation, not its input transfer. Configuration
// writes are to be made only while the block is idle; the block does not
// enforce this. Writing the initial capacity register also loads the current
// capacity. The store has no reset, so an unwritten byte reads as undefined.

module char_buffer_with_growth_policy_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input channel.
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [cbg_pkg::FUNC_W-1:0]       i_func,
    input  logic [cbg_pkg::BYTE_W-1:0]       i_symbol,
    input  logic [cbg_pkg::OFF_W-1:0]        i_mark_value,
    // Output channel.
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [cbg_pkg::STATUS_W-1:0]     o_status,
    output logic [cbg_pkg::BYTE_W-1:0]       o_read_byte,
    output logic [cbg_pkg::OFF_W-1:0]        o_size_now,
    output logic [cbg_pkg::OFF_W-1:0]        o_capacity_now,
    output logic [cbg_pkg::OFF_W-1:0]        o_mark_now,
    output logic [cbg_pkg::OFF_W-1:0]        o_read_pos,
    output logic                             o_end_flag,
    output logic                             o_full_flag,
    output logic                             o_empty_flag,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [cbg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cbg_pkg::CFG_W-1:0]        i_cfg_data
);

    // Control sequencer. EXEC commits the operation; MUL and DIV compute
    // the multiplicative growth increment.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_MUL  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    logic [cbg_pkg::MODE_W-1:0]  r_growth_mode;
    logic [cbg_pkg::BYTE_W-1:0]  r_growth_factor;

    // Buffer state.
    logic [cbg_pkg::OFF_W-1:0]   r_write_off, n_write_off;
    logic [cbg_pkg::OFF_W-1:0]   r_read_off,  n_read_off;
    logic [cbg_pkg::OFF_W-1:0]   r_mark_off,  n_mark_off;
    logic [cbg_pkg::OFF_W-1:0]   r_capacity,  n_capacity;
    logic                        r_end,       n_end;

    // Latched operation.
    logic [cbg_pkg::FUNC_W-1:0]  r_func;
    logic [cbg_pkg::BYTE_W-1:0]  r_symbol;
    logic [cbg_pkg::OFF_W-1:0]   r_mark_value;

    // Growth increment pipeline.
    logic [cbg_pkg::PROD_W-1:0]  r_prod;
    logic [cbg_pkg::OFF_W-1:0]   r_inc;
    logic                        r_have_inc;

    // Output register.
    logic                        r_o_valid;
    logic [cbg_pkg::STATUS_W-1:0] r_o_status;
    logic [cbg_pkg::BYTE_W-1:0]  r_o_read_byte;
    logic [cbg_pkg::OFF_W-1:0]   r_o_size, r_o_cap, r_o_mark, r_o_rpos;
    logic                        r_o_end, r_o_full, r_o_empty;

    logic                        in_xfer;
    logic                        out_free;
    logic                        commit;
    logic                        need_mult;
    logic [cbg_pkg::STATUS_W-1:0] op_status;
    logic [cbg_pkg::BYTE_W-1:0]  op_byte;
    logic                        ram_we;
    logic [cbg_pkg::BYTE_W-1:0]  ram_rdata;

    logic [cbg_pkg::OFF_W:0]     cap_plus_factor;
    logic [cbg_pkg::OFF_W:0]     wo_plus_one;
    logic [cbg_pkg::OFF_W-1:0]   grow_cap;
    logic [cbg_pkg::OFF_W-1:0]   free_space;
    logic [cbg_pkg::PCT_W-1:0]   factor_sat;
    logic [cbg_pkg::QPROD_W-1:0] recip_full;

    assign in_xfer  = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE);
    assign out_free = !r_o_valid || !i_stall;
    assign commit   = (r_state == S_EXEC) && !need_mult && out_free;

    assign cap_plus_factor = {1'b0, r_capacity} + (cbg_pkg::OFF_W + 1)'(r_growth_factor);
    assign wo_plus_one     = {1'b0, r_write_off} + (cbg_pkg::OFF_W + 1)'(1);
    assign free_space      = cbg_pkg::CAP_MAX - r_capacity;
    assign factor_sat      = (r_growth_factor > cbg_pkg::BYTE_W'(cbg_pkg::PCT))
                             ? cbg_pkg::PCT_W'(cbg_pkg::PCT)
                             : r_growth_factor[cbg_pkg::PCT_W-1:0];
    assign recip_full      = cbg_pkg::QPROD_W'(r_prod)
                             * cbg_pkg::QPROD_W'(cbg_pkg::RECIP_MULT);

    // Operation decode and next buffer state. The next state is only taken when committing.
    always_comb begin
        n_write_off = r_write_off;
        n_read_off  = r_read_off;
        n_mark_off  = r_mark_off;
        n_capacity  = r_capacity;
        n_end       = r_end;
        op_status   = cbg_pkg::ST_OK;
        op_byte     = '0;
        ram_we      = 1'b0;
        need_mult   = 1'b0;
        grow_cap    = r_capacity;
        unique case (r_func)
            cbg_pkg::FN_ADD: begin
                if (r_write_off >= cbg_pkg::CAP_MAX) begin
                    op_status = cbg_pkg::ST_REFUSED;
                end else if (r_write_off < r_capacity) begin
                    ram_we      = 1'b1;
                    n_write_off = r_write_off + cbg_pkg::OFF_W'(1);
                end else if (r_growth_factor == '0) begin
                    op_status = cbg_pkg::ST_REFUSED;
                end else begin
                    // Full: grow by the configured rule, then store; fixed mode refuses.
                    case (r_growth_mode)
                        cbg_pkg::GM_ADD: begin
                            if (cap_plus_factor > cbg_pkg::CAP_MAX_X) begin
                                op_status = cbg_pkg::ST_REFUSED;
                            end else begin
                                grow_cap = cap_plus_factor[cbg_pkg::OFF_W-1:0];
                            end
                        end
                        cbg_pkg::GM_MULT: begin
                            if (r_capacity >= cbg_pkg::CAP_MAX) begin
                                op_status = cbg_pkg::ST_REFUSED;
                            end else if (!r_have_inc) begin
                                need_mult = 1'b1;
                            end else if (r_inc == '0) begin
                                grow_cap = cbg_pkg::CAP_MAX;
                            end else begin
                                grow_cap = r_capacity + r_inc;
                            end
                        end
                        default: begin
                            op_status = cbg_pkg::ST_REFUSED;
                        end
                    endcase
                    if (op_status == cbg_pkg::ST_OK && !need_mult) begin
                        ram_we     = 1'b1;
                        n_capacity = grow_cap;
                        if (r_write_off < grow_cap) begin
                            n_write_off = r_write_off + cbg_pkg::OFF_W'(1);
                        end
                    end
                end
            end
            cbg_pkg::FN_GET: begin
                if (r_read_off >= r_write_off || r_read_off >= cbg_pkg::CAP_MAX) begin
                    n_end     = 1'b1;
                    op_status = cbg_pkg::ST_END;
                end else begin
                    n_end      = 1'b0;
                    op_byte    = ram_rdata;
                    n_read_off = r_read_off + cbg_pkg::OFF_W'(1);
                end
            end
            cbg_pkg::FN_RETRACT: begin
                if (r_read_off == '0) begin
                    op_status = cbg_pkg::ST_REFUSED;
                end else begin
                    n_read_off = r_read_off - cbg_pkg::OFF_W'(1);
                end
            end
            cbg_pkg::FN_RETRACT_MRK: begin
                n_read_off = r_mark_off;
            end
            cbg_pkg::FN_SET_MARK: begin
                if (r_mark_value > r_write_off) begin
                    op_status = cbg_pkg::ST_REFUSED;
                end else begin
                    n_mark_off = r_mark_value;
                end
            end
            cbg_pkg::FN_RESET: begin
                n_write_off = '0;
                n_read_off  = '0;
                n_mark_off  = '0;
                n_end       = 1'b0;
            end
            cbg_pkg::FN_PACK: begin
                if (wo_plus_one > cbg_pkg::CAP_MAX_X) begin
                    op_status = cbg_pkg::ST_REFUSED;
                end else begin
                    n_capacity = wo_plus_one[cbg_pkg::OFF_W-1:0];
                end
            end
            default: begin
                op_status = cbg_pkg::ST_REFUSED;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (need_mult) begin
                    n_state = S_MUL;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                n_state = S_EXEC;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_growth_mode   <= '0;
            r_growth_factor <= '0;
            r_write_off     <= '0;
            r_read_off      <= '0;
            r_mark_off      <= '0;
            r_capacity      <= '0;
            r_end           <= 1'b0;
            r_have_inc      <= 1'b0;
            r_o_valid       <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_xfer) begin
                r_have_inc <= 1'b0;
            end else if (r_state == S_DIV) begin
                r_have_inc <= 1'b1;
            end

            if (commit) begin
                r_write_off <= n_write_off;
                r_read_off  <= n_read_off;
                r_mark_off  <= n_mark_off;
                r_capacity  <= n_capacity;
                r_end       <= n_end;
            end

            // Configuration writes are to arrive only while idle; the block does not enforce this.
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    cbg_pkg::CFG_GROWTH_MODE: begin
                        r_growth_mode <= i_cfg_data[cbg_pkg::MODE_W-1:0];
                    end
                    cbg_pkg::CFG_GROWTH_FACTOR: begin
                        r_growth_factor <= i_cfg_data[cbg_pkg::BYTE_W-1:0];
                    end
                    cbg_pkg::CFG_INIT_CAP: begin
                        r_capacity <= (i_cfg_data[cbg_pkg::OFF_W-1:0] > cbg_pkg::CAP_MAX)
                                      ? cbg_pkg::CAP_MAX
                                      : i_cfg_data[cbg_pkg::OFF_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (commit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func       <= i_func;
            r_symbol     <= i_symbol;
            r_mark_value <= i_mark_value;
        end
        if (r_state == S_MUL) begin
            r_prod <= cbg_pkg::PROD_W'(free_space) * cbg_pkg::PROD_W'(factor_sat);
        end
        if (r_state == S_DIV) begin
            r_inc <= recip_full[cbg_pkg::RECIP_SHIFT +: cbg_pkg::OFF_W];
        end
        if (commit) begin
            r_o_status    <= op_status;
            r_o_read_byte <= op_byte;
            r_o_size      <= n_write_off;
            r_o_cap       <= n_capacity;
            r_o_mark      <= n_mark_off;
            r_o_rpos      <= n_read_off;
            r_o_end       <= n_end;
            r_o_full      <= (n_write_off == n_capacity);
            r_o_empty     <= (n_write_off == '0);
        end
    end

    // Byte store: the read for a get is issued with the input transfer.
    cbg_ram #(
        .WIDTH (cbg_pkg::BYTE_W),
        .DEPTH (cbg_pkg::MAX_CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (commit && ram_we),
        .i_waddr (r_write_off),
        .i_wdata (r_symbol),
        .i_re    (in_xfer),
        .i_raddr (r_read_off),
        .o_rdata (ram_rdata)
    );

    assign o_valid        = r_o_valid;
    assign o_status       = r_o_status;
    assign o_read_byte    = r_o_read_byte;
    assign o_size_now     = r_o_size;
    assign o_capacity_now = r_o_cap;
    assign o_mark_now     = r_o_mark;
    assign o_read_pos     = r_o_rpos;
    assign o_end_flag     = r_o_end;
    assign o_full_flag    = r_o_full;
    assign o_empty_flag   = r_o_empty;

endmodule

// ===== hdl/cbg_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No package dependency.
`timescale 1ns / 1ps

module cbg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
